[sv/u2l_pkg.sv]
// ----------------------------------------------------------------------------
// u2l_pkg
// Shared widths, status codes and types for the UTF-8 to Latin-1 transcoder.
// ----------------------------------------------------------------------------
package u2l_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned LEFT_W   = 2;

	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [LEFT_W-1:0]   left_t;

	// Result status codes
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_BAD_LEAD = 2'd1;
	localparam status_t ST_RANGE    = 2'd2;
	localparam status_t ST_TRUNC    = 2'd3;

	// Continuation counts opened by each kind of lead byte
	localparam left_t LEFT_IDLE = 2'd0;
	localparam left_t LEFT_ONE  = 2'd1;
	localparam left_t LEFT_TWO  = 2'd2;
	localparam left_t LEFT_3    = 2'd3;

endpackage

[sv/u2l_byte_if.sv]
// ----------------------------------------------------------------------------
// u2l_byte_if
// Valid/ready channel that carries one raw UTF-8 byte per transaction.
// ----------------------------------------------------------------------------
interface u2l_byte_if;

	logic           valid;
	logic           ready;
	u2l_pkg::byte_t in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);

endinterface

[sv/u2l_char_if.sv]
// ----------------------------------------------------------------------------
// u2l_char_if
// Valid/ready channel that carries one Latin-1 character and its status.
// ----------------------------------------------------------------------------
interface u2l_char_if;

	logic             valid;
	logic             ready;
	u2l_pkg::byte_t   out_byte;
	u2l_pkg::status_t status;

	modport source (output valid, output out_byte, output status, input ready);
	modport sink   (input valid, input out_byte, input status, output ready);

endinterface

[sv/utf8_to_latin1_transcoder_unit.sv]
// ----------------------------------------------------------------------------
// utf8_to_latin1_transcoder_unit
// Decodes a UTF-8 byte stream into Latin-1 characters, one byte per cycle while no result is stalled.
// ----------------------------------------------------------------------------
// A byte is captured in the input register and decoded against the sequence
// state; any result it yields is loaded into the result register and offered.
// Throughput: one byte per cycle, set by the single decode stage between the
// input register and the result register; a stalled result blocks one byte.
// Reset: arst_n clears the valid flags and the sequence state (idle).
module utf8_to_latin1_transcoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	u2l_byte_if.sink   byte_ch,
	u2l_char_if.source char_ch
);

	// Input stage
	logic           valid_s1;
	u2l_pkg::byte_t byte_s1;

	// Sequence state
	u2l_pkg::left_t bytes_left_q;
	u2l_pkg::byte_t partial_q;
	logic           overflow_q;

	// Result register
	logic             valid_s2;
	u2l_pkg::byte_t   out_byte_s2;
	u2l_pkg::status_t status_s2;

	// Decode outputs
	u2l_pkg::left_t   left_d;
	u2l_pkg::byte_t   partial_d;
	logic             overflow_d;
	logic             emit_d;
	u2l_pkg::byte_t   char_d;
	u2l_pkg::status_t status_d;
	logic             ovf_acc;
	u2l_pkg::byte_t   shifted;

	logic advance;

	// Advance the decode stage when the result register is free or drains
	assign advance      = !valid_s2 || char_ch.ready;
	assign byte_ch.ready = !valid_s1 || advance;

	// Decode one byte against the sequence state
	always_comb begin
		left_d     = bytes_left_q;
		partial_d  = partial_q;
		overflow_d = overflow_q;
		emit_d     = 1'b0;
		char_d     = '0;
		status_d   = u2l_pkg::ST_OK;
		ovf_acc    = overflow_q | (partial_q[7:2] != 6'd0);
		shifted    = {partial_q[1:0], byte_s1[5:0]};
		if (bytes_left_q == u2l_pkg::LEFT_IDLE) begin
			if (!byte_s1[7]) begin
				emit_d = 1'b1;
				char_d = byte_s1;
			end else begin
				overflow_d = 1'b0;
				if (byte_s1[7:4] == 4'hF) begin
					partial_d = {5'd0, byte_s1[2:0]};
					left_d    = u2l_pkg::LEFT_3;
				end else if (byte_s1[7:5] == 3'b111) begin
					partial_d = {4'd0, byte_s1[3:0]};
					left_d    = u2l_pkg::LEFT_TWO;
				end else if (byte_s1[7:6] == 2'b11) begin
					partial_d = {3'd0, byte_s1[4:0]};
					left_d    = u2l_pkg::LEFT_ONE;
				end else begin
					partial_d = '0;
					emit_d    = 1'b1;
					status_d  = u2l_pkg::ST_BAD_LEAD;
				end
			end
		end else if (byte_s1 == '0) begin
			// Zero byte cuts the sequence short
			left_d     = u2l_pkg::LEFT_IDLE;
			partial_d  = '0;
			overflow_d = 1'b0;
			emit_d     = 1'b1;
			status_d   = u2l_pkg::ST_TRUNC;
		end else begin
			left_d = bytes_left_q - u2l_pkg::LEFT_ONE;
			if (bytes_left_q == u2l_pkg::LEFT_ONE) begin
				partial_d  = '0;
				overflow_d = 1'b0;
				emit_d     = 1'b1;
				if (ovf_acc) begin
					status_d = u2l_pkg::ST_RANGE;
				end else begin
					char_d = shifted;
				end
			end else begin
				partial_d  = shifted;
				overflow_d = ovf_acc;
			end
		end
	end

	// Capture accepted bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1 <= byte_ch.in_byte;
		end
	end

	// Update sequence state as each byte leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= u2l_pkg::LEFT_IDLE;
			partial_q    <= '0;
			overflow_q   <= 1'b0;
		end else if (valid_s1 && advance) begin
			bytes_left_q <= left_d;
			partial_q    <= partial_d;
			overflow_q   <= overflow_d;
		end
	end

	// Load or drain the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && emit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit_d) begin
			out_byte_s2 <= char_d;
			status_s2   <= status_d;
		end
	end

	assign char_ch.valid    = valid_s2;
	assign char_ch.out_byte = out_byte_s2;
	assign char_ch.status   = status_s2;

endmodule

[sv/u2l_checker.sv]
// ----------------------------------------------------------------------------
// u2l_checker
// Port-level checks for the transcoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module u2l_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input u2l_pkg::byte_t   out_byte,
	input u2l_pkg::status_t status
);

	// Error results carry a zero character
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != u2l_pkg::ST_OK) |-> out_byte == '0)
		else $error("error result with nonzero character");

	// Input backpressure only comes from a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output is free");

	// Input stays ready while no result is pending
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |=> in_ready || out_valid)
		else $error("input stalled with no pending result");

	// Stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status))
		else $error("stalled result changed");

endmodule

bind utf8_to_latin1_transcoder_unit u2l_checker u_u2l_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (byte_ch.ready),
	.out_valid (char_ch.valid),
	.out_ready (char_ch.ready),
	.out_byte  (char_ch.out_byte),
	.status    (char_ch.status)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 to Latin-1 transcoder. A short table of
// hand-picked byte sequences runs first, then random character sequences,
// mostly well formed with some stray, truncated and noise bytes. Every
// accepted byte goes through a local decoder model, and every character
// transaction is compared against the oldest pending prediction. Both
// channels idle at random, and the character side holds off once for a long
// stretch so the unit backs up and stalls its byte input.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned RANDOM_BYTES   = 1950;
	localparam int unsigned SQUEEZE_AFTER  = 300;
	localparam int unsigned SQUEEZE_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES   = 10;
	localparam int unsigned DIR_ROWS       = 25;

	typedef struct packed {
		u2l_pkg::byte_t   ch;
		u2l_pkg::status_t st;
	} latin1_t;

	typedef struct packed {
		u2l_pkg::byte_t   b;
		logic             fixed;
		u2l_pkg::byte_t   ch;
		u2l_pkg::status_t st;
	} dir_row_t;

	logic clk;
	logic arst_n;

	u2l_byte_if byte_ch ();
	u2l_char_if char_ch ();

	utf8_to_latin1_transcoder_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.char_ch (char_ch)
	);

	// Decoder model state
	u2l_pkg::left_t seq_left;
	u2l_pkg::byte_t code_low;
	bit             beyond_latin1;

	latin1_t     pending_chars[$];
	int unsigned mismatches;
	int unsigned bytes_sent;
	int unsigned give_burst;
	int unsigned take_burst;
	bit          squeeze_req;
	bit          squeeze_done;

	// Directed sequences; a typed result where it is obvious, else predicted
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{8'h00, 1'b1, 8'h00, u2l_pkg::ST_OK},        // zero byte while idle passes
		'{8'h7F, 1'b1, 8'h7F, u2l_pkg::ST_OK},        // highest ASCII
		'{8'h80, 1'b1, 8'h00, u2l_pkg::ST_BAD_LEAD},  // stray continuation, low end
		'{8'hBF, 1'b1, 8'h00, u2l_pkg::ST_BAD_LEAD},  // stray continuation, high end
		'{8'hC3, 1'b0, 8'h00, u2l_pkg::ST_OK},        // two-byte e-acute
		'{8'hA9, 1'b0, 8'h00, u2l_pkg::ST_OK},
		'{8'hC2, 1'b0, 8'h00, u2l_pkg::ST_OK},        // two-byte 0x80
		'{8'h80, 1'b0, 8'h00, u2l_pkg::ST_OK},
		'{8'hC4, 1'b0, 8'h00, u2l_pkg::ST_OK},        // 0x100, just out of range
		'{8'h80, 1'b1, 8'h00, u2l_pkg::ST_RANGE},
		'{8'hE0, 1'b0, 8'h00, u2l_pkg::ST_OK},        // overlong three-byte 0xFF
		'{8'h83, 1'b0, 8'h00, u2l_pkg::ST_OK},
		'{8'hBF, 1'b0, 8'h00, u2l_pkg::ST_OK},
		'{8'hF0, 1'b0, 8'h00, u2l_pkg::ST_OK},        // overlong four-byte 'A'
		'{8'h80, 1'b0, 8'h00, u2l_pkg::ST_OK},
		'{8'h81, 1'b0, 8'h00, u2l_pkg::ST_OK},
		'{8'h81, 1'b0, 8'h00, u2l_pkg::ST_OK},
		'{8'hC3, 1'b0, 8'h00, u2l_pkg::ST_OK},        // zero inside a sequence
		'{8'h00, 1'b1, 8'h00, u2l_pkg::ST_TRUNC},
		'{8'hFF, 1'b0, 8'h00, u2l_pkg::ST_OK},        // 0xFF lead taken as four-byte
		'{8'hFF, 1'b0, 8'h00, u2l_pkg::ST_OK},
		'{8'hFF, 1'b0, 8'h00, u2l_pkg::ST_OK},
		'{8'hFF, 1'b1, 8'h00, u2l_pkg::ST_RANGE},
		'{8'hC1, 1'b0, 8'h00, u2l_pkg::ST_OK},        // unchecked 11xxxxxx continuation
		'{8'hFF, 1'b0, 8'h00, u2l_pkg::ST_OK}
	};

	// Clock and reset
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Advance the decoder model by one byte; return 1 when it yields a character
	function automatic bit decode_step(input u2l_pkg::byte_t b, output u2l_pkg::byte_t ch,
			output u2l_pkg::status_t st);
		ch = '0;
		st = u2l_pkg::ST_OK;
		if (seq_left == u2l_pkg::LEFT_IDLE) begin
			if (!b[7]) begin
				ch = b;
				return 1'b1;
			end
			beyond_latin1 = 1'b0;
			if (b[7:4] == 4'hF) begin
				code_low = {5'd0, b[2:0]};
				seq_left = u2l_pkg::LEFT_3;
			end else if (b[7:5] == 3'b111) begin
				code_low = {4'd0, b[3:0]};
				seq_left = u2l_pkg::LEFT_TWO;
			end else if (b[7:6] == 2'b11) begin
				code_low = {3'd0, b[4:0]};
				seq_left = u2l_pkg::LEFT_ONE;
			end else begin
				code_low = '0;
				st = u2l_pkg::ST_BAD_LEAD;
				return 1'b1;
			end
			return 1'b0;
		end
		// a zero byte cuts the sequence short
		if (b == '0) begin
			seq_left = u2l_pkg::LEFT_IDLE;
			code_low = '0;
			beyond_latin1 = 1'b0;
			st = u2l_pkg::ST_TRUNC;
			return 1'b1;
		end
		// shift in six bits; anything pushed past bit 7 puts the code point out of range
		if (code_low[7:2] != '0)
			beyond_latin1 = 1'b1;
		code_low = {code_low[1:0], b[5:0]};
		seq_left = seq_left - 1'b1;
		if (seq_left != u2l_pkg::LEFT_IDLE)
			return 1'b0;
		if (beyond_latin1)
			st = u2l_pkg::ST_RANGE;
		else
			ch = code_low;
		code_low = '0;
		beyond_latin1 = 1'b0;
		return 1'b1;
	endfunction

	// Append one predicted character to the pending list
	function automatic void log_char(input latin1_t c);
		pending_chars = {pending_chars, c};
	endfunction

	// Idle length: mostly none or short, a few long, with occasional bursts of none
	function automatic int unsigned idle_len(inout int unsigned burst_left);
		int unsigned r;
		if (burst_left != 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Continuation byte with the given payload; mostly 10xxxxxx, never zero
	function automatic u2l_pkg::byte_t cont_byte(input logic [5:0] payload);
		u2l_pkg::byte_t v;
		v = {2'b10, payload};
		if ($urandom_range(0, 9) == 0)
			v[7:6] = 2'($urandom_range(0, 3));
		if (v == '0)
			v = 8'h40;
		return v;
	endfunction

	// Offer one byte, hold it until accepted, then log its predicted character
	task automatic send_byte(input u2l_pkg::byte_t b, input bit fixed,
			input u2l_pkg::byte_t fix_ch, input u2l_pkg::status_t fix_st);
		int unsigned      gap;
		u2l_pkg::byte_t   ch;
		u2l_pkg::status_t st;
		bit               hit;
		gap = idle_len(give_burst);
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.in_byte <= b;
		do
			@(posedge clk);
		while (!byte_ch.ready);
		hit = decode_step(b, ch, st);
		if (fixed)
			log_char('{fix_ch, fix_st});
		else if (hit)
			log_char('{ch, st});
		bytes_sent++;
	endtask

	// One random character: ASCII, stray, noise, or a multi-byte sequence
	task automatic send_random_char();
		u2l_pkg::byte_t seq[4];
		int unsigned    r;
		int unsigned    len;
		int unsigned    stop;
		bit             fits;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			send_byte(u2l_pkg::byte_t'($urandom_range(0, 8'h7F)), 1'b0, '0, u2l_pkg::ST_OK);
		end else if (r < 30) begin
			send_byte(u2l_pkg::byte_t'($urandom_range(8'h80, 8'hBF)), 1'b0, '0,
				u2l_pkg::ST_OK);
		end else if (r < 35) begin
			send_byte(u2l_pkg::byte_t'($urandom_range(0, 8'hFF)), 1'b0, '0, u2l_pkg::ST_OK);
		end else begin
			len  = $urandom_range(2, 4);
			fits = 1'($urandom_range(0, 1));
			case (len)
				2: begin
					seq[0] = fits ? u2l_pkg::byte_t'(8'hC0 | $urandom_range(0, 3))
						: u2l_pkg::byte_t'(8'hC0 | $urandom_range(0, 31));
					seq[1] = cont_byte(6'($urandom_range(0, 63)));
				end
				3: begin
					seq[0] = fits ? 8'hE0 : u2l_pkg::byte_t'(8'hE0 | $urandom_range(0, 15));
					seq[1] = cont_byte(6'(fits ? $urandom_range(0, 3) : $urandom_range(0, 63)));
					seq[2] = cont_byte(6'($urandom_range(0, 63)));
				end
				default: begin
					seq[0] = fits ? u2l_pkg::byte_t'(8'hF0 | ($urandom_range(0, 1) << 3))
						: u2l_pkg::byte_t'(8'hF0 | $urandom_range(0, 15));
					seq[1] = cont_byte(fits ? 6'd0 : 6'($urandom_range(0, 63)));
					seq[2] = cont_byte(6'(fits ? $urandom_range(0, 3) : $urandom_range(0, 63)));
					seq[3] = cont_byte(6'($urandom_range(0, 63)));
				end
			endcase
			// cut some sequences short with a zero byte
			stop = len;
			if ($urandom_range(0, 9) == 0) begin
				stop = $urandom_range(1, len - 1);
				seq[stop] = '0;
				stop++;
			end
			for (int unsigned i = 0; i < stop; i++)
				send_byte(seq[i], 1'b0, '0, u2l_pkg::ST_OK);
		end
	endtask

	// Byte side: directed table, random part, drain, verdict
	initial begin
		byte_ch.valid   <= 1'b0;
		byte_ch.in_byte <= '0;
		seq_left      = u2l_pkg::LEFT_IDLE;
		code_low      = '0;
		beyond_latin1 = 1'b0;
		mismatches    = 0;
		bytes_sent    = 0;
		give_burst    = 0;
		squeeze_req   = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		for (int unsigned i = 0; i < DIR_ROWS; i++)
			send_byte(dir_rows[i].b, dir_rows[i].fixed, dir_rows[i].ch, dir_rows[i].st);
		while (bytes_sent < DIR_ROWS + RANDOM_BYTES) begin
			if (bytes_sent >= DIR_ROWS + SQUEEZE_AFTER)
				squeeze_req = 1'b1;
			send_random_char();
		end
		byte_ch.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[utf8_to_latin1_transcoder_unit] OK");
		else
			$display("[utf8_to_latin1_transcoder_unit] ERROR");
		$finish;
	end

	// Character side: random stalls, plus one long hold-off
	initial begin
		int unsigned n;
		char_ch.ready <= 1'b0;
		take_burst   = 0;
		squeeze_done = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (squeeze_req && !squeeze_done) begin
				char_ch.ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				squeeze_done = 1'b1;
			end else begin
				n = idle_len(take_burst);
				if (n == 0) begin
					char_ch.ready <= 1'b1;
					@(posedge clk);
				end else begin
					char_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// Check each character transaction against the oldest prediction
	always @(posedge clk) begin
		latin1_t want;
		if (arst_n && char_ch.valid && char_ch.ready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character: expected none, got out_byte %h status %0d",
					$time, char_ch.out_byte, char_ch.status);
				mismatches++;
			end else begin
				want = pending_chars.pop_front();
				if (char_ch.out_byte !== want.ch) begin
					$display("%0t: out_byte mismatch: expected %h, got %h",
						$time, want.ch, char_ch.out_byte);
					mismatches++;
				end
				if (char_ch.status !== want.st) begin
					$display("%0t: status mismatch: expected %0d, got %0d",
						$time, want.st, char_ch.status);
					mismatches++;
				end
			end
		end
	end

	// Hard stop if the run hangs
	initial begin
		#8000000;
		$display("[utf8_to_latin1_transcoder_unit] ERROR");
		$finish;
	end

endmodule

[sim.f]
sv/u2l_pkg.sv
sv/u2l_byte_if.sv
sv/u2l_char_if.sv
sv/utf8_to_latin1_transcoder_unit.sv
sv/u2l_checker.sv
tb/testbench.sv
